FILE: hdl/frp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_pkg
// Types, codes and constants shared by the FASTA record parser modules.
// ----------------------------------------------------------------------------
package frp_pkg;

  // Input transfer: one byte of text or an end-of-stream marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } frp_in_t;

  typedef enum logic [1:0] {
    KIND_ID   = 2'd0,
    KIND_DESC = 2'd1,
    KIND_SEQ  = 2'd2,
    KIND_END  = 2'd3
  } frp_kind_e;

  // Output transfer: one result.
  typedef struct packed {
    logic [7:0] out_byte;
    frp_kind_e  field_kind;
    logic       run_last;
    logic       pending_overflow;
  } frp_out_t;

  // Commands from the classifier to the emitter.
  typedef enum logic [1:0] {
    OP_EMIT       = 2'd0,  // one result, byte and kind as given
    OP_HOLD       = 2'd1,  // hold description whitespace, flush first if full
    OP_FLUSH_EMIT = 2'd2,  // release held whitespace, then the description byte
    OP_CLEAR      = 2'd3   // drop held whitespace, no result
  } frp_op_e;

  typedef struct packed {
    frp_op_e    op;
    logic [7:0] data;
    frp_kind_e  kind;
  } frp_cmd_t;

  localparam logic [7:0] CHAR_TITLE   = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;  // '\n'
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int         APB_ADDR_W      = 3;
  localparam logic [2:0] REG_KEEP_WS_ADR = 3'd0;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

FILE: hdl/frp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_front
// Classifier: tracks the parse phase and turns each byte into a command.
// ----------------------------------------------------------------------------
module frp_front import frp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  frp_in_t  in_data_i,
  output logic     in_stall_o,
  input  logic     keep_ws_i,
  output logic     cmd_push_o,
  output frp_cmd_t cmd_o,
  input  logic     cmd_full_i
);

  typedef enum logic [2:0] {
    PH_SEEK      = 3'd0,
    PH_ID_LEAD   = 3'd1,
    PH_ID        = 3'd2,
    PH_DESC_LEAD = 3'd3,
    PH_DESC      = 3'd4,
    PH_SEQ       = 3'd5
  } phase_e;

  phase_e   phase_q, phase_d;
  logic     open_q, open_d;
  logic     cmd_vld;
  frp_cmd_t cmd;
  logic     accept;
  logic     ws;
  logic [7:0] c;

  assign in_stall_o = cmd_full_i;
  assign accept     = in_valid_i && !cmd_full_i;
  assign c          = in_data_i.data_byte;
  assign ws         = is_ws(c);

  always_comb begin
    phase_d  = phase_q;
    open_d   = open_q;
    cmd_vld  = 1'b0;
    cmd.op   = OP_EMIT;
    cmd.data = c;
    cmd.kind = KIND_ID;
    if (in_data_i.stream_end) begin
      if (open_q) begin
        cmd_vld  = 1'b1;
        cmd.data = 8'd0;
        cmd.kind = KIND_END;
      end
      open_d  = 1'b0;
      phase_d = PH_SEEK;
    end else begin
      case (phase_q)
        PH_SEEK: begin
          if (c == CHAR_TITLE) begin
            open_d  = 1'b1;
            phase_d = PH_ID_LEAD;
          end
        end
        PH_ID_LEAD, PH_ID, PH_DESC_LEAD, PH_DESC: begin
          if (c == CHAR_NEWLINE) begin
            // trailing description whitespace is dropped
            cmd_vld = 1'b1;
            cmd.op  = OP_CLEAR;
            phase_d = PH_SEQ;
          end else if (phase_q == PH_ID_LEAD) begin
            if (!ws) begin
              cmd_vld = 1'b1;
              phase_d = PH_ID;
            end
          end else if (phase_q == PH_ID) begin
            if (ws) begin
              phase_d = PH_DESC_LEAD;
            end else begin
              cmd_vld = 1'b1;
            end
          end else if (phase_q == PH_DESC_LEAD) begin
            if (!ws) begin
              cmd_vld  = 1'b1;
              cmd.kind = KIND_DESC;
              phase_d  = PH_DESC;
            end
          end else begin
            cmd_vld  = 1'b1;
            cmd.kind = KIND_DESC;
            cmd.op   = ws ? OP_HOLD : OP_FLUSH_EMIT;
          end
        end
        PH_SEQ: begin
          if (c == CHAR_TITLE) begin
            cmd_vld  = 1'b1;
            cmd.data = 8'd0;
            cmd.kind = KIND_END;
            open_d   = 1'b1;
            phase_d  = PH_ID_LEAD;
          end else if (!ws || keep_ws_i) begin
            cmd_vld  = 1'b1;
            cmd.kind = KIND_SEQ;
          end
        end
        default: begin
          phase_d = PH_SEEK;
        end
      endcase
    end
  end

  assign cmd_push_o = accept && cmd_vld;
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
      open_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      open_q  <= open_d;
    end
  end

endmodule

FILE: hdl/frp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_fifo
// Short command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module frp_fifo import frp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  frp_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output frp_cmd_t data_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frp_cmd_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]    count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: hdl/frp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_back
// Emitter: executes commands, owns the held-whitespace store, drives results.
// ----------------------------------------------------------------------------
module frp_back import frp_pkg::*; #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  frp_cmd_t cmd_i,
  output logic     cmd_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output frp_out_t out_data_o
);

  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);

  logic [7:0]    ws_mem [PENDING_DEPTH];
  logic [7:0]    rdata_q;
  logic [CW-1:0] count_q;
  logic [AW-1:0] idx_q;

  // read stage
  logic       s1_vld_q;
  logic       s1_mem_q;
  logic [7:0] s1_byte_q;
  frp_kind_e  s1_kind_q;
  logic       s1_last_q;
  logic       s1_ovf_q;

  logic     out_vld_q;
  frp_out_t out_q;

  logic s1_adv, s1_free;
  logic full, is_hold;
  logic do_single, do_flush, do_hold, do_clear, flush_end;
  logic mem_we;
  logic [AW-1:0] mem_wa;

  assign s1_adv  = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign s1_free = !s1_vld_q || s1_adv;
  assign full    = (count_q == CW'(PENDING_DEPTH));
  assign is_hold = (cmd_i.op == OP_HOLD);

  assign do_single = cmd_valid_i && s1_free &&
                     ((cmd_i.op == OP_EMIT) ||
                      ((cmd_i.op == OP_FLUSH_EMIT) && (count_q == '0)));
  assign do_flush  = cmd_valid_i && s1_free && (count_q != '0) &&
                     ((cmd_i.op == OP_FLUSH_EMIT) || (is_hold && full));
  assign do_hold   = cmd_valid_i && is_hold && !full;
  assign do_clear  = cmd_valid_i && (cmd_i.op == OP_CLEAR);
  assign flush_end = do_flush && ((CW'(idx_q) + 1'b1) == count_q);

  assign cmd_pop_o = do_single || do_hold || do_clear || (flush_end && is_hold);

  // an overflowing hold refills the store from slot zero
  assign mem_we = do_hold || (flush_end && is_hold);
  assign mem_wa = do_hold ? count_q[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ws_mem[mem_wa] <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_flush) begin
      rdata_q <= ws_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_mem_q  <= do_flush;
      s1_byte_q <= cmd_i.data;
      s1_kind_q <= do_flush ? KIND_DESC : cmd_i.kind;
      s1_last_q <= do_single || (flush_end && is_hold);
      s1_ovf_q  <= do_flush && is_hold;
    end
    if (s1_adv) begin
      out_q.out_byte         <= s1_mem_q ? rdata_q : s1_byte_q;
      out_q.field_kind       <= s1_kind_q;
      out_q.run_last         <= s1_last_q;
      out_q.pending_overflow <= s1_ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      idx_q     <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (do_hold) begin
        count_q <= count_q + 1'b1;
      end else if (flush_end) begin
        count_q <= is_hold ? CW'(1) : '0;
      end else if (do_clear || (do_single && (cmd_i.kind == KIND_END))) begin
        count_q <= '0;
      end
      if (do_flush) begin
        idx_q <= flush_end ? '0 : idx_q + 1'b1;
      end
      if (s1_free) begin
        s1_vld_q <= do_single || do_flush;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_flush_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_flush |-> (CW'(idx_q) < count_q))
    else $error("flush index beyond held count");

  a_ovf_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_end && is_hold) |=> (count_q == CW'(1)))
    else $error("overflowing hold did not leave one held byte");

  a_ovf_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.pending_overflow) |-> (out_q.field_kind == KIND_DESC))
    else $error("overflow flag on a non-description result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_hold |=> (count_q <= CW'(PENDING_DEPTH)))
    else $error("held count above store depth");

endmodule

FILE: hdl/fasta_record_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_record_parser
// FASTA text parser: splits titles into id and description, passes sequence.
// ----------------------------------------------------------------------------
// The parser takes one text byte per transfer and accepts a byte every cycle
// while its four-entry command queue has room. Most bytes cause zero or one
// result, emitted at one per cycle unless the output stalls. A description
// byte that releases held whitespace first has every held byte read out, and a
// whitespace byte that finds the hold store full (PENDING_DEPTH entries)
// first flushes all of it; the single read port of the hold store paces
// these runs. The queue absorbs short runs, after which the input stalls. A
// byte's command is queued, then passes a registered read stage and an
// output register before its first result is offered. The hold store needs
// no clearing after reset. The user writes the only register, keep_whitespace
// at address 0, only while the parser idles; the block does not enforce it.
// ----------------------------------------------------------------------------
module fasta_record_parser import frp_pkg::*; #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // byte input
  input  logic                  in_valid_i,
  input  frp_in_t               in_data_i,
  output logic                  in_stall_o,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output frp_out_t              out_data_o,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic     keep_ws_q;
  logic     cmd_push, cmd_full, cmd_pop, cmd_valid;
  frp_cmd_t cmd_in, cmd_out;
  logic     reg_wr;

  // Register write completes on the access phase; pready never stalls.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr == REG_KEEP_WS_ADR);
  assign prdata = (paddr == REG_KEEP_WS_ADR) ? {31'd0, keep_ws_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_ws_q <= 1'b0;
    end else if (reg_wr) begin
      keep_ws_q <= pwdata[0];
    end
  end

  // Front end: classify each byte, one command at most per transfer.
  frp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .keep_ws_i  (keep_ws_q),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  // Queue: lets the classifier keep taking bytes during whitespace flushes.
  frp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .valid_o     (cmd_valid),
    .data_o      (cmd_out)
  );

  // Back end: hold store, flush sequencing and the result register.
  frp_back #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
